// ----- hw/rtl/sfb_pkg.sv -----
// shared types, constants and a helper function for the scaled flip blit address generator
// used by every module under hw/rtl but sfb_div; depends on nothing
package sfb_pkg;

   // default parameter values
   localparam int MAX_DIM_DEF   = 4096;
   localparam int MAX_DEPTH_DEF = 4;
   localparam int FRAC_BITS_DEF = 16;

   // fixed field widths
   localparam int REG_W      = 32;
   localparam int COORD_W    = 16;
   localparam int STRIDE_W   = 13;
   localparam int DEPTH_W    = 3;
   localparam int OFF_W      = 26;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HORIZ   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_VERT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_HORIZ   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DST_VERT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DST_WIDTH   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_DEPTH = 3'd6;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_PLACE,
      ST_ROW,
      ST_SCALE,
      ST_LOAD
   } state_type;

   // what the word in flight turns into
   typedef enum logic [1:0] {
      KIND_RESTART,
      KIND_EMPTY,
      KIND_PIXEL
   } kind_type;

   typedef struct packed {
      logic [REG_W-1:0]    src_horiz;
      logic [REG_W-1:0]    src_vert;
      logic [REG_W-1:0]    dst_horiz;
      logic [REG_W-1:0]    dst_vert;
      logic [STRIDE_W-1:0] src_width;
      logic [STRIDE_W-1:0] dst_width;
      logic [DEPTH_W-1:0]  pixel_depth;
   } cfg_type;

   typedef struct packed {
      logic     div_start;
      logic     step_en;
      logic     place_en;
      logic     row_en;
      logic     scale_en;
      logic     commit;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic running;
      logic span_zero;
   } status_type;

   // pixel i of a rect axis, mirrored when the start lies past the end
   function automatic logic [OFF_W-1:0] place(input logic [COORD_W-1:0] first_c,
                                              input logic [COORD_W-1:0] last_c,
                                              input logic [OFF_W-1:0]   idx);
      logic [OFF_W-1:0] base;
      base = OFF_W'(first_c);
      if (first_c > last_c) begin
         return base - idx - OFF_W'(1);
      end else begin
         return base + idx;
      end
   endfunction

endpackage

// ----- hw/rtl/sfb_div.sv -----
// restoring divider lane, one quotient bit per cycle
// depends on nothing; used by sfb_datapath
module sfb_div #(
   parameter int NUM_W = 29,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // one trial subtraction
   always_comb begin
      trial = {rem_ff, quot_ff[NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
   end

   // next iteration
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quot_in = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- hw/rtl/sfb_csr.sv -----
// configuration registers of the blit address generator
// depends on sfb_pkg
module sfb_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sfb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfb_pkg::REG_W-1:0]       csr_data,
   output sfb_pkg::cfg_type                cfg
);
   import sfb_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // decode a write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SRC_HORIZ:   cfg_in.src_horiz   = csr_data;
            REG_SRC_VERT:    cfg_in.src_vert    = csr_data;
            REG_DST_HORIZ:   cfg_in.dst_horiz   = csr_data;
            REG_DST_VERT:    cfg_in.dst_vert    = csr_data;
            REG_SRC_WIDTH:   cfg_in.src_width   = csr_data[STRIDE_W-1:0];
            REG_DST_WIDTH:   cfg_in.dst_width   = csr_data[STRIDE_W-1:0];
            REG_PIXEL_DEPTH: cfg_in.pixel_depth = csr_data[DEPTH_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_horiz   <= '0;
         cfg_ff.src_vert    <= '0;
         cfg_ff.dst_horiz   <= '0;
         cfg_ff.dst_vert    <= '0;
         cfg_ff.src_width   <= STRIDE_W'(1);
         cfg_ff.dst_width   <= STRIDE_W'(1);
         cfg_ff.pixel_depth <= DEPTH_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// ----- hw/rtl/sfb_ctrl.sv -----
// sequencing state machine for the blit address generator
// depends on sfb_pkg; drives the datapath through cmd_type and reads status_type
module sfb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_restart,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  sfb_pkg::status_type  status,
   output sfb_pkg::cmd_type     cmd
);
   import sfb_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_restart) begin
                  state_in = ST_DIV;
                  kind_in  = KIND_RESTART;
               end else if (!status.running || status.span_zero) begin
                  state_in = ST_LOAD;
                  kind_in  = KIND_EMPTY;
               end else begin
                  state_in = ST_MUL;
                  kind_in  = KIND_PIXEL;
               end
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_MUL:   state_in = ST_PLACE;
         ST_PLACE: state_in = ST_ROW;
         ST_ROW:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_LOAD;
         ST_LOAD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.kind   = kind_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.div_start = req_tvalid && req_restart;
         end
         ST_MUL:   cmd.step_en  = 1'b1;
         ST_PLACE: cmd.place_en = 1'b1;
         ST_ROW:   cmd.row_en   = 1'b1;
         ST_SCALE: cmd.scale_en = 1'b1;
         ST_LOAD:  cmd.commit   = out_free;
         default:  cmd          = '0;
      endcase
   end

   // result word valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= KIND_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- hw/rtl/sfb_datapath.sv -----
// datapath: spans, step dividers, pixel counters and the offset pipeline
// depends on sfb_pkg and sfb_div; controlled by sfb_ctrl
module sfb_datapath #(
   parameter int MAX_DIM   = sfb_pkg::MAX_DIM_DEF,
   parameter int MAX_DEPTH = sfb_pkg::MAX_DEPTH_DEF,
   parameter int FRAC_BITS = sfb_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sfb_pkg::cfg_type             cfg,
   input  sfb_pkg::cmd_type             cmd,
   output sfb_pkg::status_type          status,
   output logic                         out_active,
   output logic                         out_last,
   output logic [sfb_pkg::OFF_W-1:0]    out_dst,
   output logic [sfb_pkg::OFF_W-1:0]    out_src
);
   import sfb_pkg::*;

   localparam int SPAN_W  = $clog2(MAX_DIM + 1);
   localparam int CNT_W   = $clog2(MAX_DIM);
   localparam int CMP_W   = CNT_W + 1;
   localparam int STEP_W  = SPAN_W + FRAC_BITS;
   localparam int PROD_W  = CNT_W + STEP_W;
   localparam int ROWP_W  = OFF_W + STRIDE_W;
   localparam int SCALE_W = OFF_W + DEPTH_W;

   // spans of the four rect registers
   logic [SPAN_W-1:0] sw, sh, dw, dh;

   function automatic logic [SPAN_W-1:0] span_of(input logic [REG_W-1:0] r);
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
      logic [COORD_W-1:0] d;
      lo = r[COORD_W-1:0];
      hi = r[REG_W-1:COORD_W];
      d  = (hi > lo) ? hi - lo : lo - hi;
      if (d > COORD_W'(MAX_DIM)) begin
         return SPAN_W'(MAX_DIM);
      end else begin
         return SPAN_W'(d);
      end
   endfunction

   always_comb begin
      sw = span_of(cfg.src_horiz);
      sh = span_of(cfg.src_vert);
      dw = span_of(cfg.dst_horiz);
      dh = span_of(cfg.dst_vert);
   end

   // step dividers, both axes in lockstep
   logic              done_x, done_y;
   logic [STEP_W-1:0] quot_x, quot_y;

   sfb_div #(.NUM_W(STEP_W), .DEN_W(SPAN_W)) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (STEP_W'(sw) << FRAC_BITS),
      .den   (dw),
      .done  (done_x),
      .quot  (quot_x)
   );

   sfb_div #(.NUM_W(STEP_W), .DEN_W(SPAN_W)) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (STEP_W'(sh) << FRAC_BITS),
      .den   (dh),
      .done  (done_y),
      .quot  (quot_y)
   );

   // blit state
   logic [CNT_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [STEP_W-1:0] step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic              running_ff, running_in;

   // offset pipeline registers
   logic [OFF_W-1:0] sx_idx_ff, sy_idx_ff;
   logic [OFF_W-1:0] dx_ff, dy_ff, sx_ff, sy_ff;
   logic [OFF_W-1:0] dst_row_ff, src_row_ff;
   logic [OFF_W-1:0] pix_dst_ff, pix_src_ff;
   logic             out_active_ff, out_last_ff;
   logic [OFF_W-1:0] out_dst_ff, out_src_ff;

   // combinational pieces of each stage
   logic [PROD_W-1:0]  prod_x, prod_y;
   logic [ROWP_W-1:0]  dst_row_full, src_row_full;
   logic [DEPTH_W-1:0] depth;
   logic [OFF_W-1:0]   dst_sum, src_sum;
   logic [SCALE_W-1:0] dst_scaled, src_scaled;
   logic [CMP_W-1:0]   col_next, row_next;
   logic               row_end, last;

   always_comb begin
      prod_x       = PROD_W'(col_ff) * PROD_W'(step_x_ff);
      prod_y       = PROD_W'(row_ff) * PROD_W'(step_y_ff);
      dst_row_full = ROWP_W'(dy_ff) * ROWP_W'(cfg.dst_width);
      src_row_full = ROWP_W'(sy_ff) * ROWP_W'(cfg.src_width);
      depth        = (cfg.pixel_depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
                                                             : cfg.pixel_depth;
      dst_sum      = dst_row_ff + dx_ff;
      src_sum      = src_row_ff + sx_ff;
      dst_scaled   = SCALE_W'(dst_sum) * SCALE_W'(depth);
      src_scaled   = SCALE_W'(src_sum) * SCALE_W'(depth);
      col_next     = CMP_W'(col_ff) + CMP_W'(1);
      row_next     = CMP_W'(row_ff) + CMP_W'(1);
      row_end      = (col_next >= CMP_W'(dw));
      last         = row_end && (row_next >= CMP_W'(dh));
   end

   // pipeline stages
   always_ff @(posedge clock) begin
      if (cmd.step_en) begin
         sx_idx_ff <= OFF_W'(prod_x >> FRAC_BITS);
         sy_idx_ff <= OFF_W'(prod_y >> FRAC_BITS);
      end
      if (cmd.place_en) begin
         dx_ff <= place(cfg.dst_horiz[COORD_W-1:0], cfg.dst_horiz[REG_W-1:COORD_W],
                        OFF_W'(col_ff));
         dy_ff <= place(cfg.dst_vert[COORD_W-1:0], cfg.dst_vert[REG_W-1:COORD_W],
                        OFF_W'(row_ff));
         sx_ff <= place(cfg.src_horiz[COORD_W-1:0], cfg.src_horiz[REG_W-1:COORD_W],
                        sx_idx_ff);
         sy_ff <= place(cfg.src_vert[COORD_W-1:0], cfg.src_vert[REG_W-1:COORD_W],
                        sy_idx_ff);
      end
      if (cmd.row_en) begin
         dst_row_ff <= dst_row_full[OFF_W-1:0];
         src_row_ff <= src_row_full[OFF_W-1:0];
      end
      if (cmd.scale_en) begin
         pix_dst_ff <= dst_scaled[OFF_W-1:0];
         pix_src_ff <= src_scaled[OFF_W-1:0];
      end
   end

   // commit of one word: blit state update
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      step_x_in  = step_x_ff;
      step_y_in  = step_y_ff;
      running_in = running_ff;
      if (cmd.commit) begin
         unique case (cmd.kind)
            KIND_RESTART: begin
               step_x_in  = (dw == '0) ? '0 : quot_x + STEP_W'(1);
               step_y_in  = (dh == '0) ? '0 : quot_y + STEP_W'(1);
               col_in     = '0;
               row_in     = '0;
               running_in = (dw != '0) && (dh != '0);
            end
            KIND_EMPTY: begin
               running_in = 1'b0;
            end
            KIND_PIXEL: begin
               if (last) begin
                  running_in = 1'b0;
                  col_in     = '0;
                  row_in     = '0;
               end else if (row_end) begin
                  col_in = '0;
                  row_in = row_next[CNT_W-1:0];
               end else begin
                  col_in = col_next[CNT_W-1:0];
               end
            end
            default: running_in = running_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         step_x_ff  <= '0;
         step_y_ff  <= '0;
         running_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         step_x_ff  <= step_x_in;
         step_y_ff  <= step_y_in;
         running_ff <= running_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (cmd.kind == KIND_PIXEL) begin
            out_active_ff <= 1'b1;
            out_last_ff   <= last;
            out_dst_ff    <= pix_dst_ff;
            out_src_ff    <= pix_src_ff;
         end else begin
            out_active_ff <= 1'b0;
            out_last_ff   <= 1'b0;
            out_dst_ff    <= '0;
            out_src_ff    <= '0;
         end
      end
   end

   always_comb begin
      status.div_done  = done_x && done_y;
      status.running   = running_ff;
      status.span_zero = (dw == '0) || (dh == '0);
   end

   assign out_active = out_active_ff;
   assign out_last   = out_last_ff;
   assign out_dst    = out_dst_ff;
   assign out_src    = out_src_ff;

endmodule

// ----- hw/rtl/scaled_flip_blit_address_gen_unit.sv -----
// Scaled flip blit address generator: nearest-neighbor source and destination byte offsets.
// req carries one word per item: restart (1) computes the per-axis steps and clears the
//   pixel counters, tick (0) asks for the next destination pixel, row by row.
// rsp returns exactly one word per req word: tuser = active (pixel pair present),
//   tlast = last pixel of the blit, tdata = destination and source byte offsets.
//   Restart words and ticks with no blit running or a zero destination span return an all-zero word.
// csr writes the rect, stride and depth registers; write only while no word is in flight.
// One word is worked on at a time: the next req word is taken only after the result of the
//   last one is loaded. A tick of a running blit passes the step multiply, rect placement,
//   row multiply and depth scale stages before its result is loaded; a tick with no blit
//   running goes straight to the result register.
//   A restart runs the two restoring dividers one quotient bit per cycle over clog2(MAX_DIM+1)
//   plus FRAC_BITS quotient bits (29 at the defaults) before its result is loaded.
// The result register lets req words be taken while an older result waits on rsp_tready;
//   a stalled receiver only holds the block at the point where the next result is loaded.
// Reset (synchronous, active high) clears the counters, the steps and the running flag,
//   loads the registers with their reset values and drops rsp_tvalid.
// Depends on sfb_pkg, sfb_csr, sfb_ctrl, sfb_datapath and sfb_div.
module scaled_flip_blit_address_gen_unit #(
   parameter int MAX_DIM   = sfb_pkg::MAX_DIM_DEF,
   parameter int MAX_DEPTH = sfb_pkg::MAX_DEPTH_DEF,
   parameter int FRAC_BITS = sfb_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // input words
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sfb_pkg::REQ_DATA_W-1:0]     req_tdata,   // [0] restart, [7:1] zero
   // result words
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sfb_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [25:0] dst_offset, [51:26] src_offset
   output logic                               rsp_tuser,   // [0] active
   output logic                               rsp_tlast,   // last_pixel
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sfb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sfb_pkg::REG_W-1:0]          csr_data
);
   import sfb_pkg::*;

   cfg_type          cfg;
   cmd_type          cmd;
   status_type       status;
   logic [OFF_W-1:0] out_dst, out_src;

   // configuration registers
   sfb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // controller
   sfb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_restart (req_tdata[0]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd)
   );

   // datapath
   sfb_datapath #(
      .MAX_DIM   (MAX_DIM),
      .MAX_DEPTH (MAX_DEPTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .out_active (rsp_tuser),
      .out_last   (rsp_tlast),
      .out_dst    (out_dst),
      .out_src    (out_src)
   );

   // pack the result word
   assign rsp_tdata = {{(RSP_DATA_W - 2 * OFF_W){1'b0}}, out_src, out_dst};

   // one word in flight: no second accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted again right after an accept");

   // the last flag only rides on a pixel word
   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("last pixel flag on a word without a pixel");

   // words without a pixel carry zero offsets
   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("non-pixel word with nonzero offsets");

endmodule

// ----- dv/scaled_flip_blit_address_gen_unit_tb.sv -----
// self-checking testbench for the scaled flip blit address generator: directed table, receiver
// hold-off, then random blits checked word by word against a behavioral address predictor
// depends on sfb_pkg and scaled_flip_blit_address_gen_unit
module scaled_flip_blit_address_gen_unit_tb;
   import sfb_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 900;

   // one result word split into fields
   typedef struct packed {
      logic             active;
      logic             last;
      logic [OFF_W-1:0] dst_off;
      logic [OFF_W-1:0] src_off;
   } addr_pair_type;

   typedef enum bit {ROW_WRITE, ROW_ITEM} row_kind_type;

   // one line of the directed table: a register write or an input word
   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [REG_W-1:0]     data;
      bit                   restart;
      bit                   typed;
      addr_pair_type        want;
   } plan_row_type;

   typedef enum logic [1:0] {RDY_ALWAYS, RDY_PATTERN, RDY_RANDOM} ready_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [REG_W-1:0]      csr_data   = '0;

   // predictor state: register copy, steps, counters
   cfg_type           shadow;
   longint unsigned   step_x, step_y;
   int unsigned       col_cnt, row_cnt;
   bit                blit_on;

   addr_pair_type     pairs_due[$];
   int unsigned       mismatches    = 0;
   int unsigned       results_seen  = 0;
   int unsigned       pixels_seen   = 0;
   int unsigned       lasts_seen    = 0;
   int unsigned       words_sent    = 0;
   int unsigned       restarts_sent = 0;
   int unsigned       cycles        = 0;
   int unsigned       burst_left    = 0;
   bit                steady        = 1'b0;
   logic              hold_ask      = 1'b0;

   // receiver stall state
   int unsigned       stall_phase = 0;
   ready_mode_type    ready_mode  = RDY_ALWAYS;
   logic [31:0]       stall_mask  = '1;
   int unsigned       hold_left   = 0;
   bit                hold_taken  = 1'b0;

   scaled_flip_blit_address_gen_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // rect span, saturated to the largest image size
   function automatic int unsigned axis_span(input logic [REG_W-1:0] r);
      int unsigned a, b, d;
      a = r[15:0];
      b = r[31:16];
      d = (b > a) ? b - a : a - b;
      return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : d;
   endfunction

   // coordinate of pixel i along one axis, mirrored when start lies past end
   function automatic longint unsigned axis_pos(input logic [REG_W-1:0] r,
                                                input longint unsigned i);
      longint unsigned s, e;
      s = r[15:0];
      e = r[31:16];
      return (s > e) ? s - i - 1 : s + i;
   endfunction

   function automatic longint unsigned step_ratio(input int unsigned sspan,
                                                  input int unsigned dspan);
      longint unsigned t;
      t = sspan;
      if (dspan == 0) return 0;
      return ((t << FRAC_BITS_DEF) / dspan) + 1;
   endfunction

   function automatic logic [OFF_W-1:0] to_bytes(input longint unsigned y,
                                                 input longint unsigned x,
                                                 input logic [STRIDE_W-1:0] stride);
      longint unsigned d;
      d = (shadow.pixel_depth > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : shadow.pixel_depth;
      return OFF_W'((y * stride + x) * d);
   endfunction

   // address pair for one accepted input word, advancing the blit walk
   function automatic addr_pair_type gen_addr_pair(input bit restart_bit);
      addr_pair_type   r;
      int unsigned     dw, dh;
      longint unsigned x, y, dx, dy, sx, sy;
      bit              row_end, fin;
      r  = '0;
      dw = axis_span(shadow.dst_horiz);
      dh = axis_span(shadow.dst_vert);
      if (restart_bit) begin
         step_x  = step_ratio(axis_span(shadow.src_horiz), dw);
         step_y  = step_ratio(axis_span(shadow.src_vert), dh);
         col_cnt = 0;
         row_cnt = 0;
         blit_on = (dw != 0) && (dh != 0);
         return r;
      end
      if (!blit_on) return r;
      if (dw == 0 || dh == 0) begin
         blit_on = 1'b0;
         return r;
      end
      x  = col_cnt;
      y  = row_cnt;
      dx = axis_pos(shadow.dst_horiz, x);
      dy = axis_pos(shadow.dst_vert, y);
      sx = axis_pos(shadow.src_horiz, (x * step_x) >> FRAC_BITS_DEF);
      sy = axis_pos(shadow.src_vert, (y * step_y) >> FRAC_BITS_DEF);
      row_end   = (col_cnt + 1 >= dw);
      fin       = row_end && (row_cnt + 1 >= dh);
      r.active  = 1'b1;
      r.last    = fin;
      r.dst_off = to_bytes(dy, dx, shadow.dst_width);
      r.src_off = to_bytes(sy, sx, shadow.src_width);
      if (fin) begin
         blit_on = 1'b0;
         col_cnt = 0;
         row_cnt = 0;
      end else if (row_end) begin
         col_cnt = 0;
         row_cnt = (row_cnt + 1) & 32'hFFF;
      end else begin
         col_cnt = (col_cnt + 1) & 32'hFFF;
      end
      return r;
   endfunction

   // rect of the given span at a random place, optionally mirrored
   function automatic logic [REG_W-1:0] make_rect(input int unsigned span, input bit mirror);
      int unsigned base;
      base = $urandom_range(0, 65535 - span);
      return mirror ? {16'(base), 16'(base + span)} : {16'(base + span), 16'(base)};
   endfunction

   function automatic int unsigned dst_span_pick();
      int unsigned r;
      r = $urandom_range(0, 11);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(7, 65535);
      return $urandom_range(1, 6);
   endfunction

   function automatic int unsigned src_span_pick();
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) return $urandom_range(0, 65535);
      if (r == 1) return MAX_DIM_DEF;
      return $urandom_range(0, 24);
   endfunction

   // upper bits beyond the stride width are don't-care and sometimes get random values
   function automatic logic [REG_W-1:0] stride_pick();
      int unsigned r;
      r = $urandom_range(0, 5);
      if (r == 0) return {19'($urandom), 13'($urandom)};
      if (r == 1) return ($urandom_range(0, 1) != 0) ? 32'd8191 : 32'd0;
      return $urandom_range(1, 64);
   endfunction

   function automatic logic [REG_W-1:0] depth_pick();
      if ($urandom_range(0, 3) == 0) return {29'($urandom), 3'($urandom)};
      return $urandom_range(1, 4);
   endfunction

   function automatic plan_row_type wr(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [REG_W-1:0] data);
      plan_row_type r;
      r      = '0;
      r.kind = ROW_WRITE;
      r.idx  = idx;
      r.data = data;
      return r;
   endfunction

   function automatic plan_row_type tk(input bit restart_bit);
      plan_row_type r;
      r         = '0;
      r.kind    = ROW_ITEM;
      r.restart = restart_bit;
      return r;
   endfunction

   function automatic plan_row_type ck(input bit restart_bit, input logic act, input logic fin,
                                       input logic [OFF_W-1:0] d, input logic [OFF_W-1:0] s);
      plan_row_type r;
      r       = tk(restart_bit);
      r.typed = 1'b1;
      r.want  = '{act, fin, d, s};
      return r;
   endfunction

   // offer one input word, then maybe leave a gap between bursts
   task automatic push_word(input bit restart_bit, input bit typed,
                            input addr_pair_type typed_pair);
      addr_pair_type due;
      int unsigned   gap;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(restart_bit);
      do @(posedge clock); while (!req_tready);
      due = gen_addr_pair(restart_bit);
      pairs_due.push_back(typed ? typed_pair : due);
      words_sent++;
      if (restart_bit) restarts_sent++;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (!steady) gap = $urandom_range(1, 10);
      end else begin
         burst_left--;
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pairs_due.size() != 0) @(posedge clock);
   endtask

   // register write, only with no word in flight
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
      wait_drained();
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_SRC_HORIZ:   shadow.src_horiz   = value;
         REG_SRC_VERT:    shadow.src_vert    = value;
         REG_DST_HORIZ:   shadow.dst_horiz   = value;
         REG_DST_VERT:    shadow.dst_vert    = value;
         REG_SRC_WIDTH:   shadow.src_width   = value[STRIDE_W-1:0];
         REG_DST_WIDTH:   shadow.dst_width   = value[STRIDE_W-1:0];
         REG_PIXEL_DEPTH: shadow.pixel_depth = value[DEPTH_W-1:0];
         default: ;
      endcase
   endtask

   // one blit setup, restart and a walk over its pixels, optionally with a write mid-walk
   task automatic run_blit(input bit tweak);
      int unsigned      dw_s, dh_s, ticks, cut;
      logic [CSR_IDX_W-1:0] pick;
      steady = ($urandom_range(0, 4) == 0);
      dw_s   = dst_span_pick();
      dh_s   = dst_span_pick();
      write_reg(REG_DST_HORIZ, make_rect(dw_s, $urandom_range(0, 1)));
      write_reg(REG_DST_VERT, make_rect(dh_s, $urandom_range(0, 1)));
      write_reg(REG_SRC_HORIZ, make_rect(src_span_pick(), $urandom_range(0, 1)));
      write_reg(REG_SRC_VERT, make_rect(src_span_pick(), $urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) write_reg(REG_SRC_WIDTH, stride_pick());
      if ($urandom_range(0, 2) == 0) write_reg(REG_DST_WIDTH, stride_pick());
      if ($urandom_range(0, 2) == 0) write_reg(REG_PIXEL_DEPTH, depth_pick());
      push_word(1'b1, 1'b0, '0);
      // big rects get a random tick count and may be walked only partly
      ticks = (dw_s > 6 || dh_s > 6) ? $urandom_range(4, 40) : dw_s * dh_s;
      ticks = ticks + $urandom_range((ticks == 0) ? 1 : 0, 2);
      cut   = tweak ? $urandom_range(0, ticks) : ticks;
      repeat (cut) push_word(1'b0, 1'b0, '0);
      if (tweak) begin
         pick = CSR_IDX_W'($urandom_range(0, 6));
         case (pick)
            REG_DST_HORIZ, REG_DST_VERT:
               write_reg(pick, make_rect($urandom_range(0, 6), $urandom_range(0, 1)));
            REG_SRC_HORIZ, REG_SRC_VERT:
               write_reg(pick, make_rect(src_span_pick(), $urandom_range(0, 1)));
            REG_SRC_WIDTH, REG_DST_WIDTH:
               write_reg(pick, stride_pick());
            default:
               write_reg(REG_PIXEL_DEPTH, depth_pick());
         endcase
         repeat (ticks - cut) push_word(1'b0, 1'b0, '0);
      end
   endtask

   // receiver: changing stall pattern, plus one long hold-off on request
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 2));
         stall_mask <= $urandom;
      end
      if (hold_ask && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_ask) hold_taken <= 1'b0;
         case (ready_mode)
            RDY_ALWAYS:  rsp_tready <= 1'b1;
            RDY_PATTERN: rsp_tready <= stall_mask[stall_phase % 32];
            default:     rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // compare each result word with the oldest expected pair
   always @(posedge clock) begin : check_results
      addr_pair_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.active  = rsp_tuser;
         got.last    = rsp_tlast;
         got.dst_off = rsp_tdata[OFF_W-1:0];
         got.src_off = rsp_tdata[2*OFF_W-1:OFF_W];
         results_seen++;
         if (got.active === 1'b1) pixels_seen++;
         if (got.last === 1'b1) lasts_seen++;
         if (pairs_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: active %b last %b dst 0x%h src 0x%h",
                        got.active, got.last, got.dst_off, got.src_off);
         end else begin
            want = pairs_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result %0d: expected active %b last %b dst 0x%h src 0x%h",
                           results_seen, want.active, want.last, want.dst_off,
                           want.src_off);
                  $display("   got active %b last %b dst 0x%h src 0x%h",
                           got.active, got.last, got.dst_off, got.src_off);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycles, pairs_due.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      plan_row_type plan[$];
      plan_row_type row;
      int unsigned  n, target;

      // predictor starts from the reset values
      shadow             = '0;
      shadow.src_width   = 1;
      shadow.dst_width   = 1;
      shadow.pixel_depth = 1;
      step_x  = 0;
      step_y  = 0;
      col_cnt = 0;
      row_cnt = 0;
      blit_on = 1'b0;

      // idle tick, restart on empty rects, zero destination ends at once
      plan.push_back(ck(1'b0, 1'b0, 1'b0, '0, '0));
      plan.push_back(ck(1'b1, 1'b0, 1'b0, '0, '0));
      plan.push_back(ck(1'b0, 1'b0, 1'b0, '0, '0));
      // single pixel blit, then idle
      plan.push_back(wr(REG_DST_HORIZ, {16'd1, 16'd0}));
      plan.push_back(wr(REG_DST_VERT, {16'd1, 16'd0}));
      plan.push_back(ck(1'b1, 1'b0, 1'b0, '0, '0));
      plan.push_back(ck(1'b0, 1'b1, 1'b1, '0, '0));
      plan.push_back(ck(1'b0, 1'b0, 1'b0, '0, '0));
      // saturated and mirrored spans, widest source stride, depth above range
      plan.push_back(wr(REG_SRC_HORIZ, {16'hFFFF, 16'h0000}));
      plan.push_back(wr(REG_SRC_VERT, {16'h0000, 16'hFFFF}));
      plan.push_back(wr(REG_DST_HORIZ, {16'h0000, 16'h0003}));
      plan.push_back(wr(REG_DST_VERT, {16'h0002, 16'h0000}));
      plan.push_back(wr(REG_SRC_WIDTH, 32'd8191));
      plan.push_back(wr(REG_DST_WIDTH, 32'd4096));
      plan.push_back(wr(REG_PIXEL_DEPTH, 32'd7));
      plan.push_back(tk(1'b1));
      repeat (6) plan.push_back(tk(1'b0));
      // zero depth gives zero offsets, zero stride
      plan.push_back(wr(REG_PIXEL_DEPTH, 32'd0));
      plan.push_back(wr(REG_SRC_WIDTH, 32'd0));
      plan.push_back(ck(1'b1, 1'b0, 1'b0, '0, '0));
      plan.push_back(ck(1'b0, 1'b1, 1'b0, '0, '0));
      plan.push_back(tk(1'b0));
      // destination span cleared mid blit ends it
      plan.push_back(wr(REG_DST_VERT, 32'h0000_0000));
      plan.push_back(ck(1'b0, 1'b0, 1'b0, '0, '0));
      plan.push_back(ck(1'b0, 1'b0, 1'b0, '0, '0));
      // counters left beyond a shrunk span
      plan.push_back(wr(REG_PIXEL_DEPTH, 32'd4));
      plan.push_back(wr(REG_DST_VERT, {16'd2, 16'd0}));
      plan.push_back(tk(1'b1));
      repeat (4) plan.push_back(tk(1'b0));
      plan.push_back(wr(REG_DST_HORIZ, {16'd1, 16'd0}));
      plan.push_back(tk(1'b0));
      plan.push_back(tk(1'b0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_WRITE) write_reg(row.idx, row.data);
         else push_word(row.restart, row.typed, row.want);
      end

      // long receiver hold-off while ticks keep coming, input must back up
      write_reg(REG_DST_HORIZ, make_rect(6, 1'b0));
      write_reg(REG_DST_VERT, make_rect(6, 1'b1));
      steady = 1'b1;
      push_word(1'b1, 1'b0, '0);
      hold_ask <= 1'b1;
      repeat (24) push_word(1'b0, 1'b0, '0);
      wait_drained();
      hold_ask <= 1'b0;

      // random blits, some with mid-walk writes, and some noise
      target = words_sent + RANDOM_ITEMS;
      while (words_sent < target) begin
         n = $urandom_range(0, 9);
         if (n == 0) begin
            steady = $urandom_range(0, 1);
            repeat ($urandom_range(1, 8)) push_word($urandom_range(0, 3) == 0, 1'b0, '0);
         end else begin
            run_blit(n == 1);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d words (%0d restarts); checked %0d results: %0d pixels, %0d blits done",
               words_sent, restarts_sent, results_seen, pixels_seen, lasts_seen);
      $display("%0d mismatches, %0d results still due", mismatches, pairs_due.size());
      if (mismatches == 0 && pairs_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
